### rtl/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg : shared constants and types for the rescore-and-sort block
// capacity, code points and the per-cell control word
// ----------------------------------------------------------------------------
package ssr_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int NUM_HINTS   = 4;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   // request modes
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_HINT   = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_HINT_ACK = 2'd0;
   localparam logic [1:0] KIND_SORTED   = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;

   // cell operations
   localparam logic [2:0] CELL_HOLD  = 3'd0;
   localparam logic [2:0] CELL_LOAD  = 3'd1;
   localparam logic [2:0] CELL_HINT  = 3'd2;
   localparam logic [2:0] CELL_SORT  = 3'd3;
   localparam logic [2:0] CELL_SHIFT = 3'd4;

   typedef struct packed {
      logic [2:0]  op;
      logic        phase;
      logic [31:0] load_word;
      logic [31:0] load_score;
      logic [31:0] hint_word;
      logic [31:0] hint_score;
   } cell_ctrl_type;

endpackage

### rtl/ssr_cell.sv
// ----------------------------------------------------------------------------
// ssr_cell : one slot of the entry chain
// holds a word and score, loads, rescores, compare-swaps and shifts left
// ----------------------------------------------------------------------------
module ssr_cell (
   input  logic                        clock,
   input  ssr_pkg::cell_ctrl_type      ctrl,
   input  logic [ssr_pkg::IDX_W-1:0]   cell_index,
   input  logic [ssr_pkg::CNT_W-1:0]   count,
   input  logic                        has_left,
   input  logic [31:0]                 left_word,
   input  logic [31:0]                 left_score,
   input  logic [31:0]                 right_word,
   input  logic [31:0]                 right_score,
   input  logic                        found_in,
   output logic                        found_out,
   output logic [31:0]                 word,
   output logic [31:0]                 score
);
   import ssr_pkg::*;

   logic [31:0]  word_ff, word_in;
   logic [31:0]  score_ff, score_in;
   logic [CNT_W:0] idx_ext;
   logic         self_valid;
   logic         right_valid;
   logic         hit;

   assign idx_ext     = {1'b0, CNT_W'(cell_index)};
   assign self_valid  = idx_ext < {1'b0, count};
   assign right_valid = (idx_ext + 1'b1) < {1'b0, count};
   assign hit         = self_valid && (word_ff == ctrl.hint_word);
   assign found_out   = found_in || hit;

   always_comb begin
      word_in  = word_ff;
      score_in = score_ff;
      case (ctrl.op)
         CELL_LOAD: begin
            if (idx_ext == {1'b0, count}) begin
               word_in  = ctrl.load_word;
               score_in = ctrl.load_score;
            end
         end
         CELL_HINT: begin
            if (hit && !found_in) begin
               score_in = ctrl.hint_score;
            end
         end
         CELL_SORT: begin
            if (cell_index[0] == ctrl.phase) begin
               // paired with right neighbour, larger score moves left
               if (right_valid && ($signed(score_ff) < $signed(right_score))) begin
                  word_in  = right_word;
                  score_in = right_score;
               end
            end else begin
               if (has_left && self_valid && ($signed(left_score) < $signed(score_ff))) begin
                  word_in  = left_word;
                  score_in = left_score;
               end
            end
         end
         CELL_SHIFT: begin
            word_in  = right_word;
            score_in = right_score;
         end
         default: begin
            word_in  = word_ff;
            score_in = score_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      score_ff <= score_in;
   end

   assign word  = word_ff;
   assign score = score_ff;

endmodule

### rtl/scored_entry_rescore_and_sort.sv
// ----------------------------------------------------------------------------
// scored_entry_rescore_and_sort : entry list with hint rescoring and sort
// a row of cells holds the list, sorts it in place and streams it out
// ----------------------------------------------------------------------------
// usage
//  - req_ channel (valid/stall) carries one word: mode, entry word, score, rank
//  - load words append an entry and give no response, unless
//    the list is full: then an overflow response is sent and the entry dropped
//  - hint words give one acknowledge response, registered the next cycle
//  - a finish word runs odd-even transposition phases in the cell row
//    (each phase compare-swaps either the even or the odd neighbour pairs),
//    then emits every entry, one per cycle while rsp_stall is low,
//    highest score first, ties in load order
//  - csr_ channel (valid/ready) writes hint_base_score, always ready;
//    write only while the block is idle
//  - req_stall is high while sorting or emitting, and while a response
//    sits in the output register under rsp_stall
//  - rsp_stall holds the output register; emission simply waits
//  - reset (synchronous) empties the list, clears the base score and
//    drops any pending response
// ----------------------------------------------------------------------------
module scored_entry_rescore_and_sort (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,
   // request words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_entry_word,
   input  logic signed [31:0] req_entry_score,
   input  logic [1:0]  req_hint_rank,
   // response words
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [31:0] rsp_out_word,
   output logic signed [31:0] rsp_out_score,
   output logic        rsp_hint_matched,
   output logic        rsp_last_entry
);
   import ssr_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SORT = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   logic [IDX_W-1:0] phase_ff, phase_in;
   logic [31:0]      base_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] oword_ff, oword_in;
   logic [31:0] oscore_ff, oscore_in;
   logic        matched_ff, matched_in;
   logic        last_ff, last_in;

   logic        req_fire;
   logic        out_free;
   logic        emit_fire;
   logic        list_full;
   logic        hint_ok;
   logic [32:0] hint_diff;
   logic [31:0] hint_score;

   cell_ctrl_type ctrl;

   logic [31:0] cell_word  [MAX_ENTRIES];
   logic [31:0] cell_score [MAX_ENTRIES];
   logic        found      [MAX_ENTRIES+1];

   // handshakes
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_fire  = req_valid && !req_stall;
   assign emit_fire = (state_ff == ST_EMIT) && out_free;
   assign list_full = (entry_count_ff == CNT_W'(MAX_ENTRIES));

   // base minus rank, saturating at the most negative score
   assign hint_ok   = {2'b00, req_hint_rank} < 4'(NUM_HINTS);
   assign hint_diff = {base_ff[31], base_ff} - {31'd0, req_hint_rank};
   assign hint_score = (hint_diff[32] && !hint_diff[31]) ? 32'h8000_0000 : hint_diff[31:0];

   // cell control word
   always_comb begin
      ctrl.op         = CELL_HOLD;
      ctrl.phase      = phase_ff[0];
      ctrl.load_word  = req_entry_word;
      ctrl.load_score = req_entry_score;
      ctrl.hint_word  = req_entry_word;
      ctrl.hint_score = hint_score;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_mode == MODE_LOAD) && !list_full) begin
               ctrl.op = CELL_LOAD;
            end else if (req_fire && (req_mode == MODE_HINT) && hint_ok) begin
               ctrl.op = CELL_HINT;
            end
         end
         ST_SORT: ctrl.op = CELL_SORT;
         ST_EMIT: begin
            if (emit_fire) begin
               ctrl.op = CELL_SHIFT;
            end
         end
         default: ctrl.op = CELL_HOLD;
      endcase
   end

   // the cell row, first match of a hint ripples from cell 0 upwards
   assign found[0] = 1'b0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [31:0] lw, ls, rw, rs;
      if (i == 0) begin : g_first
         assign lw = '0;
         assign ls = '0;
      end else begin : g_mid
         assign lw = cell_word[i-1];
         assign ls = cell_score[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign rw = '0;
         assign rs = '0;
      end else begin : g_inner
         assign rw = cell_word[i+1];
         assign rs = cell_score[i+1];
      end

      ssr_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cell_index  (IDX_W'(i)),
         .count       (entry_count_ff),
         .has_left    (i != 0),
         .left_word   (lw),
         .left_score  (ls),
         .right_word  (rw),
         .right_score (rs),
         .found_in    (found[i]),
         .found_out   (found[i+1]),
         .word        (cell_word[i]),
         .score       (cell_score[i])
      );
   end

   // sequencer and output register
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      phase_in       = phase_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      kind_in        = kind_ff;
      oword_in       = oword_ff;
      oscore_in      = oscore_ff;
      matched_in     = matched_ff;
      last_in        = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_mode)
                  MODE_LOAD: begin
                     if (list_full) begin
                        rsp_valid_in = 1'b1;
                        kind_in      = KIND_OVERFLOW;
                        oword_in     = '0;
                        oscore_in    = '0;
                        matched_in   = 1'b0;
                        last_in      = 1'b0;
                     end else begin
                        entry_count_in = entry_count_ff + 1'b1;
                     end
                  end
                  MODE_HINT: begin
                     rsp_valid_in = 1'b1;
                     kind_in      = KIND_HINT_ACK;
                     oword_in     = '0;
                     oscore_in    = '0;
                     matched_in   = hint_ok && found[MAX_ENTRIES];
                     last_in      = 1'b0;
                  end
                  MODE_FINISH: begin
                     if (entry_count_ff != '0) begin
                        state_in = ST_SORT;
                        phase_in = '0;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SORT: begin
            if (phase_ff == IDX_W'(MAX_ENTRIES - 1)) begin
               state_in = ST_EMIT;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in   = 1'b1;
               kind_in        = KIND_SORTED;
               oword_in       = cell_word[0];
               oscore_in      = cell_score[0];
               matched_in     = 1'b0;
               last_in        = (entry_count_ff == CNT_W'(1));
               entry_count_in = entry_count_ff - 1'b1;
               if (entry_count_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         phase_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         base_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         phase_ff       <= phase_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            base_ff <= csr_data;
         end
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      oword_ff   <= oword_in;
      oscore_ff  <= oscore_in;
      matched_ff <= matched_in;
      last_ff    <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_out_word     = oword_ff;
   assign rsp_out_score    = oscore_ff;
   assign rsp_hint_matched = matched_ff;
   assign rsp_last_entry   = last_ff;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond capacity");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while sorting or emitting");

   a_sort_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT) |-> (entry_count_ff != '0))
      else $error("sorting an empty list");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && (entry_count_ff == CNT_W'(1))) |=>
         ((state_ff == ST_IDLE) && (entry_count_ff == '0) && rsp_valid_ff && last_ff))
      else $error("list not cleared after last sorted word");

endmodule
